/* rtl/core/pfrg_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the percentile frame-rate governor.
package pfrg_pkg;

	// Field widths of the channels and the stored state.
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned INTERVAL_W = 20;
	localparam int unsigned WORKER_W   = 32;
	localparam int unsigned SAMPLE_W   = 31;
	localparam int unsigned HELD_W     = 5;
	localparam int unsigned CHANGES_W  = 32;
	localparam int unsigned FPS_W      = 6;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INTERVAL_FAST = 3'd0,
		CFG_INTERVAL_MID  = 3'd1,
		CFG_INTERVAL_SLOW = 3'd2,
		CFG_RISE_TO_FAST  = 3'd3,
		CFG_RISE_TO_MID   = 3'd4
	} cfg_reg_t;

	// Reset values of the configuration registers.
	localparam logic [INTERVAL_W-1:0] RST_INTERVAL_FAST = 20'd16667;
	localparam logic [INTERVAL_W-1:0] RST_INTERVAL_MID  = 20'd33333;
	localparam logic [INTERVAL_W-1:0] RST_INTERVAL_SLOW = 20'd50000;
	localparam logic [INTERVAL_W-1:0] RST_RISE_TO_FAST  = 20'd13333;
	localparam logic [INTERVAL_W-1:0] RST_RISE_TO_MID   = 20'd26667;

	// Target rate codes and their frame rates.
	typedef enum logic [1:0] {
		RATE_60 = 2'd0,
		RATE_30 = 2'd1,
		RATE_20 = 2'd2
	} rate_t;

	localparam logic [FPS_W-1:0] FPS_FAST = 6'd60;
	localparam logic [FPS_W-1:0] FPS_MID  = 6'd30;
	localparam logic [FPS_W-1:0] FPS_SLOW = 6'd20;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EMIT,
		ST_SCAN,
		ST_DRAIN,
		ST_EVAL
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic store;
		logic scan;
		logic clear_counts;
		logic decide;
		logic load_out;
		logic done;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic window_last;
		logic found;
		logic out_free;
	} dp_status_t;

endpackage

/* rtl/core/pfrg_if.sv */
`timescale 1ns / 1ps
// Channel interfaces of the governor: input events, results and configuration writes.

interface pfrg_req_if
	import pfrg_pkg::*;
();
	logic                       valid;
	logic                       ready;
	logic                       presented;
	logic signed [WORKER_W-1:0] worker_us;

	modport source (output valid, output presented, output worker_us, input ready);
	modport sink (input valid, input presented, input worker_us, output ready);
endinterface

interface pfrg_rsp_if
	import pfrg_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic                  window_done;
	logic [1:0]            rate_code;
	logic [FPS_W-1:0]      frames_per_second;
	logic [INTERVAL_W-1:0] frame_interval_us;
	logic [SAMPLE_W-1:0]   p95_us;
	logic [HELD_W-1:0]     samples_held;
	logic [CHANGES_W-1:0]  rate_changes;

	modport source (output valid, output window_done, output rate_code,
		output frames_per_second, output frame_interval_us, output p95_us,
		output samples_held, output rate_changes, input ready);
	modport sink (input valid, input window_done, input rate_code,
		input frames_per_second, input frame_interval_us, input p95_us,
		input samples_held, input rate_changes, output ready);
endinterface

interface pfrg_cfg_if
	import pfrg_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [INTERVAL_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/core/percentile_frame_rate_governor_unit.sv */
`timescale 1ns / 1ps
// An item that does not complete a window goes through the emit state into the result register,
// and the next item is accepted only once the controller is back in the idle state.
// An item that completes a window runs a rank search first: for each candidate in turn the
// scan, drain and eval states count it against every stored sample through the dual-read
// window store, until one holds the rank. A stalled result holds the flow.
// Reset zeroes control state, rate, percentile and counters and loads the configuration
// defaults; the window store is not cleared and every entry is written before it is read.
module percentile_frame_rate_governor_unit
	import pfrg_pkg::*;
#(
	parameter int unsigned WINDOW = 32
) (
	input  logic clk,
	input  logic arst_n,
	pfrg_req_if.sink   req,
	pfrg_rsp_if.source rsp,
	pfrg_cfg_if.sink   cfg
);

	localparam int unsigned IDX_W = $clog2(WINDOW);

	dp_cmd_t          cmd;
	dp_status_t       status;
	logic [IDX_W-1:0] cand_addr, scan_addr;

	// Configuration writes are always taken.
	assign cfg.ready = 1'b1;

	pfrg_ctrl #(
		.WINDOW(WINDOW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.status    (status),
		.cmd       (cmd),
		.cand_addr (cand_addr),
		.scan_addr (scan_addr)
	);

	pfrg_dp #(
		.WINDOW(WINDOW)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_presented     (req.presented),
		.in_worker_us     (req.worker_us),
		.cfg_valid        (cfg.valid),
		.cfg_index        (cfg.index),
		.cfg_data         (cfg.data),
		.cmd              (cmd),
		.cand_addr        (cand_addr),
		.scan_addr        (scan_addr),
		.status           (status),
		.out_valid        (rsp.valid),
		.out_ready        (rsp.ready),
		.out_window_done  (rsp.window_done),
		.out_rate_code    (rsp.rate_code),
		.out_fps          (rsp.frames_per_second),
		.out_interval_us  (rsp.frame_interval_us),
		.out_p95_us       (rsp.p95_us),
		.out_samples_held (rsp.samples_held),
		.out_rate_changes (rsp.rate_changes)
	);

endmodule

/* rtl/core/pfrg_dp.sv */
`timescale 1ns / 1ps
// Datapath of the governor: window store, rank counters, rate decision and result register.
module pfrg_dp
	import pfrg_pkg::*;
#(
	parameter int unsigned WINDOW = 32,
	localparam int unsigned IDX_W = $clog2(WINDOW)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// Event payload
	input  logic                       in_presented,
	input  logic signed [WORKER_W-1:0] in_worker_us,
	// Configuration writes
	input  logic                       cfg_valid,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [INTERVAL_W-1:0]      cfg_data,
	// Controller link
	input  dp_cmd_t                    cmd,
	input  logic [IDX_W-1:0]           cand_addr,
	input  logic [IDX_W-1:0]           scan_addr,
	output dp_status_t                 status,
	// Result register
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       out_window_done,
	output logic [1:0]                 out_rate_code,
	output logic [FPS_W-1:0]           out_fps,
	output logic [INTERVAL_W-1:0]      out_interval_us,
	output logic [SAMPLE_W-1:0]        out_p95_us,
	output logic [HELD_W-1:0]          out_samples_held,
	output logic [CHANGES_W-1:0]       out_rate_changes
);

	localparam int unsigned RANK  = (WINDOW * 95 + 99) / 100 - 1;
	localparam int unsigned CNT_W = $clog2(WINDOW + 1);

	logic [INTERVAL_W-1:0] fast_q, mid_q, slow_q, rise_fast_q, rise_mid_q;
	logic [SAMPLE_W-1:0]   store_mem [WINDOW];
	logic [IDX_W-1:0]      fill_q;
	logic [SAMPLE_W-1:0]   sample;
	logic [SAMPLE_W-1:0]   rd_a_s1, rd_b_s1;
	logic                  cmp_vld_s1;
	logic [CNT_W-1:0]      lt_q, le_q;
	rate_t                 rate_q, rate_d;
	logic [SAMPLE_W-1:0]   p95_q;
	logic [CHANGES_W-1:0]  changes_q;
	logic [FPS_W-1:0]      fps;
	logic [INTERVAL_W-1:0] interval;
	logic                  out_vld_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_q      <= RST_INTERVAL_FAST;
			mid_q       <= RST_INTERVAL_MID;
			slow_q      <= RST_INTERVAL_SLOW;
			rise_fast_q <= RST_RISE_TO_FAST;
			rise_mid_q  <= RST_RISE_TO_MID;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_INTERVAL_FAST: fast_q      <= cfg_data;
				CFG_INTERVAL_MID:  mid_q       <= cfg_data;
				CFG_INTERVAL_SLOW: slow_q      <= cfg_data;
				CFG_RISE_TO_FAST:  rise_fast_q <= cfg_data;
				CFG_RISE_TO_MID:   rise_mid_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Negative worker times are stored as zero.
	assign sample = in_worker_us[WORKER_W-1] ? '0 : in_worker_us[SAMPLE_W-1:0];
	assign status.window_last = in_presented && (fill_q == IDX_W'(WINDOW - 1));

	// Fill index of the window.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cmd.store && in_presented) begin
			fill_q <= status.window_last ? '0 : fill_q + IDX_W'(1);
		end
	end

	// Window store: one write port, two registered read ports.
	always_ff @(posedge clk) begin
		if (cmd.store && in_presented) begin
			store_mem[fill_q] <= sample;
		end
	end

	always_ff @(posedge clk) begin
		rd_a_s1 <= store_mem[cand_addr];
		rd_b_s1 <= store_mem[scan_addr];
	end

	// Count the samples below and at or below the candidate.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_vld_s1 <= 1'b0;
			lt_q       <= '0;
			le_q       <= '0;
		end else begin
			cmp_vld_s1 <= cmd.scan;
			if (cmd.clear_counts) begin
				lt_q <= '0;
				le_q <= '0;
			end else if (cmp_vld_s1) begin
				lt_q <= lt_q + CNT_W'(rd_b_s1 < rd_a_s1);
				le_q <= le_q + CNT_W'(rd_b_s1 <= rd_a_s1);
			end
		end
	end

	// The candidate holds the rank when fewer samples lie below it and enough lie at or below.
	assign status.found = (lt_q <= CNT_W'(RANK)) && (le_q > CNT_W'(RANK));

	// Hysteresis decision on the candidate that holds the rank.
	always_comb begin
		rate_d = rate_q;
		case (rate_q)
			RATE_60: begin
				if (rd_a_s1 > SAMPLE_W'(mid_q)) rate_d = RATE_20;
				else if (rd_a_s1 > SAMPLE_W'(fast_q)) rate_d = RATE_30;
			end
			RATE_30: begin
				if (rd_a_s1 > SAMPLE_W'(mid_q)) rate_d = RATE_20;
				else if (rd_a_s1 <= SAMPLE_W'(rise_fast_q)) rate_d = RATE_60;
			end
			default: begin
				if (rd_a_s1 <= SAMPLE_W'(rise_mid_q)) rate_d = RATE_30;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q    <= RATE_60;
			p95_q     <= '0;
			changes_q <= '0;
		end else if (cmd.decide) begin
			rate_q <= rate_d;
			p95_q  <= rd_a_s1;
			if (rate_d != rate_q) changes_q <= changes_q + CHANGES_W'(1);
		end
	end

	// Rate number and interval for the current rate.
	always_comb begin
		case (rate_q)
			RATE_60: begin
				fps      = FPS_FAST;
				interval = fast_q;
			end
			RATE_30: begin
				fps      = FPS_MID;
				interval = mid_q;
			end
			default: begin
				fps      = FPS_SLOW;
				interval = slow_q;
			end
		endcase
	end

	// Result register.
	assign status.out_free = !out_vld_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_window_done  <= cmd.done;
			out_rate_code    <= rate_q;
			out_fps          <= fps;
			out_interval_us  <= interval;
			out_p95_us       <= p95_q;
			out_samples_held <= HELD_W'(fill_q);
			out_rate_changes <= changes_q;
		end
	end

	assign out_valid = out_vld_q;

endmodule

/* rtl/core/pfrg_ctrl.sv */
`timescale 1ns / 1ps
// Controller of the governor: event handshake, rank search sequencing and result hand-off.
module pfrg_ctrl
	import pfrg_pkg::*;
#(
	parameter int unsigned WINDOW = 32,
	localparam int unsigned IDX_W = $clog2(WINDOW)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  dp_status_t       status,
	output dp_cmd_t          cmd,
	output logic [IDX_W-1:0] cand_addr,
	output logic [IDX_W-1:0] scan_addr
);

	state_t           state_q, state_d;
	logic [IDX_W-1:0] cand_q, scan_q;
	logic             done_q;
	logic             accept;
	logic             scan_end;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign scan_end = (scan_q == IDX_W'(WINDOW - 1));

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		cmd.done = done_q;
		case (state_q)
			ST_IDLE: begin
				in_ready         = 1'b1;
				cmd.clear_counts = 1'b1;
				if (in_valid) begin
					cmd.store = 1'b1;
					state_d   = status.window_last ? ST_SCAN : ST_EMIT;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (scan_end) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (status.found) begin
					cmd.decide = 1'b1;
					state_d    = ST_EMIT;
				end else begin
					cmd.clear_counts = 1'b1;
					state_d          = ST_SCAN;
				end
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Candidate and scan counters, and the window-done flag of the pending result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q <= '0;
			scan_q <= '0;
			done_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cand_q <= '0;
					scan_q <= '0;
					if (accept) done_q <= status.window_last;
				end
				ST_SCAN: begin
					scan_q <= scan_end ? '0 : scan_q + IDX_W'(1);
				end
				ST_EVAL: begin
					if (!status.found) cand_q <= cand_q + IDX_W'(1);
				end
				default: ;
			endcase
		end
	end

	assign cand_addr = cand_q;
	assign scan_addr = scan_q;

endmodule

/* rtl/core/pfrg_chk.sv */
`timescale 1ns / 1ps
// Port checker of the governor and its binding to the top level.
module pfrg_chk
	import pfrg_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  req_valid,
	input logic                  req_ready,
	input logic                  rsp_valid,
	input logic                  rsp_ready,
	input logic                  rsp_window_done,
	input logic [1:0]            rsp_rate_code,
	input logic [FPS_W-1:0]      rsp_fps,
	input logic [INTERVAL_W-1:0] rsp_interval_us,
	input logic [SAMPLE_W-1:0]   rsp_p95_us,
	input logic [HELD_W-1:0]     rsp_samples_held,
	input logic [CHANGES_W-1:0]  rsp_rate_changes
);

	// A stalled result keeps its payload.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_window_done, rsp_rate_code,
		rsp_fps, rsp_interval_us, rsp_p95_us, rsp_samples_held, rsp_rate_changes}))
		else $error("result payload changed while stalled");

	// Items are worked one at a time: no item is taken in the cycle after an accept.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("item accepted while the previous one was still at work");

	// A completed window reports zero samples held, as the fill index has wrapped.
	a_done_empties: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_window_done |-> rsp_samples_held == '0)
		else $error("window completed but samples still held");

	// The frame rate always matches the rate code.
	a_fps_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_rate_code == RATE_60 && rsp_fps == FPS_FAST) ||
		(rsp_rate_code == RATE_30 && rsp_fps == FPS_MID) ||
		(rsp_rate_code == RATE_20 && rsp_fps == FPS_SLOW))
		else $error("frame rate does not match rate code");

endmodule

bind percentile_frame_rate_governor_unit pfrg_chk u_pfrg_chk (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_window_done  (rsp.window_done),
	.rsp_rate_code    (rsp.rate_code),
	.rsp_fps          (rsp.frames_per_second),
	.rsp_interval_us  (rsp.frame_interval_us),
	.rsp_p95_us       (rsp.p95_us),
	.rsp_samples_held (rsp.samples_held),
	.rsp_rate_changes (rsp.rate_changes)
);
